// File: hdl/pwl_pkg.sv
// Shared constants, codes and interface structs for the piecewise-linear linearizer.
// No dependencies; every other file of the block except pwl_ram imports this package.
package pwl_pkg;

    localparam int MAX_POINTS = 16;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int PT_CW      = $clog2(MAX_POINTS + 1);

    localparam int VOLT_W  = 16;
    localparam int TEMP_W  = 20;
    localparam int SEG_W   = 4;
    localparam int IDX_W   = 4;
    localparam int CFG_W   = 5;
    localparam int ENTRY_W = VOLT_W + TEMP_W;
    localparam int PROD_W  = VOLT_W + TEMP_W;
    localparam int SUM_W   = TEMP_W + 2;

    localparam int MUL_STEPS = VOLT_W;
    localparam int DIV_STEPS = TEMP_W;
    localparam int MD_CW     = $clog2(DIV_STEPS);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-3:0] REG_POINTS   = '0;
    localparam logic [CFG_W-1:0]  POINTS_RESET = CFG_W'(11);

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // Request to the serial multiply-divide unit: q = dv * mcand / dx.
    typedef struct packed {
        logic              start;
        logic [VOLT_W-1:0] dv;
        logic [TEMP_W-1:0] mcand;
        logic [VOLT_W-1:0] dx;
    } t_md_req;

    typedef struct packed {
        logic              done;
        logic [TEMP_W-1:0] quotient;
    } t_md_rsp;

endpackage

// File: hdl/pwl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/pwl_muldiv.sv
// Bit-serial unsigned multiply followed by restoring division, one bit per cycle.
// Depends on pwl_pkg for widths and the request and response structs.
module pwl_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pwl_pkg::t_md_req i_req,
    output pwl_pkg::t_md_rsp o_rsp
);
    import pwl_pkg::*;

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } t_md_state;

    t_md_state           r_state, n_state;
    logic [MD_CW-1:0]    r_cnt, n_cnt;
    logic [PROD_W-1:0]   r_acc, n_acc;
    logic [TEMP_W-1:0]   r_mcand, n_mcand;
    logic [VOLT_W-1:0]   r_dx, n_dx;
    logic [VOLT_W-1:0]   r_rem, n_rem;
    logic                r_done, n_done;

    logic [TEMP_W:0]     mul_sum;
    logic [VOLT_W:0]     div_trial;
    logic [VOLT_W:0]     div_diff;
    logic                div_ge;

    always_comb begin
        mul_sum   = {1'b0, r_acc[PROD_W-1:VOLT_W]}
                  + (r_acc[0] ? {1'b0, r_mcand} : '0);
        div_trial = {r_rem, r_acc[TEMP_W-1]};
        div_diff  = div_trial - {1'b0, r_dx};
        div_ge    = (div_trial >= {1'b0, r_dx});
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_dx    = r_dx;
        n_rem   = r_rem;
        n_done  = 1'b0;
        case (r_state)
            MD_IDLE: begin
                if (i_req.start) begin
                    n_acc   = {{(PROD_W-VOLT_W){1'b0}}, i_req.dv};
                    n_mcand = i_req.mcand;
                    n_dx    = i_req.dx;
                    n_cnt   = MD_CW'(MUL_STEPS - 1);
                    n_state = MD_MUL;
                end
            end
            MD_MUL: begin
                // Multiplier bits leave at the bottom while partial sums enter at the top.
                n_acc = {mul_sum, r_acc[VOLT_W-1:1]};
                n_cnt = r_cnt - MD_CW'(1);
                if (r_cnt == '0) begin
                    n_rem   = n_acc[PROD_W-1:TEMP_W];
                    n_cnt   = MD_CW'(DIV_STEPS - 1);
                    n_state = MD_DIV;
                end
            end
            MD_DIV: begin
                n_rem = div_ge ? div_diff[VOLT_W-1:0] : div_trial[VOLT_W-1:0];
                n_acc = {r_acc[PROD_W-1:TEMP_W], r_acc[TEMP_W-2:0], div_ge};
                n_cnt = r_cnt - MD_CW'(1);
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = MD_IDLE;
                end
            end
            default: begin
                n_state = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt   <= n_cnt;
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
        r_dx    <= n_dx;
        r_rem   <= n_rem;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_acc[TEMP_W-1:0];

endmodule

// File: hdl/piecewise_linear_sensor_linearizer_unit.sv
// Top level of the piecewise-linear sensor linearizer: command port, breakpoint
// table and segment search. Depends on pwl_pkg, pwl_ram and pwl_muldiv.
//
// A word is accepted when start is high and busy is low. A load word writes one
// breakpoint and produces no result. A convert word walks the table one entry
// per cycle through the table RAM's single read port until a segment holds the
// sample or the table ends, and runs the bit-serial multiply and divide when it
// interpolates; a miss or a zero-width segment skips them. When fewer than two
// points are in use the result comes out on the next cycle. Each result word
// is on the output ports for exactly one cycle, flagged by o_result_valid; the
// receiver cannot stall it, so it must capture every strobe it sees.
module piecewise_linear_sensor_linearizer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        start,
    output logic                        busy,
    input  logic                        i_command,
    input  logic [pwl_pkg::IDX_W-1:0]   i_point_index,
    input  logic [pwl_pkg::VOLT_W-1:0]  i_point_volt,
    input  logic signed [pwl_pkg::TEMP_W-1:0] i_point_temp,
    input  logic [pwl_pkg::VOLT_W-1:0]  i_sample_volt,

    output logic                        o_result_valid,
    output logic signed [pwl_pkg::TEMP_W-1:0] o_temperature,
    output logic                        o_in_range,
    output logic [pwl_pkg::SEG_W-1:0]   o_segment,
    output logic                        o_zero_width,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwl_pkg::APB_AW-1:0]  paddr,
    input  logic [pwl_pkg::APB_DW-1:0]  pwdata,
    output logic [pwl_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import pwl_pkg::*;

    // Search sequencer. FIRST waits for entry 0 to come out of the RAM; SCAN
    // checks one segment per cycle while the next entry is being read.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FIRST = 4'b0010,
        S_SCAN  = 4'b0100,
        S_ARITH = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [CFG_W-1:0]         r_points;
    logic [VOLT_W-1:0]        r_v, n_v;
    logic [PT_CW-1:0]         r_n, n_n;
    logic [PT_AW-1:0]         r_k, n_k;
    logic [VOLT_W-1:0]        r_prev_volt, n_prev_volt;
    logic [TEMP_W-1:0]        r_prev_temp, n_prev_temp;
    logic                     r_neg, n_neg;

    logic                     r_res_valid, n_res_valid;
    logic [TEMP_W-1:0]        r_res_temp, n_res_temp;
    logic                     r_res_hit, n_res_hit;
    logic [SEG_W-1:0]         r_res_seg, n_res_seg;
    logic                     r_res_zw, n_res_zw;

    logic                     accept;
    logic                     cfg_write;
    logic                     tbl_wr_en;
    logic [PT_AW-1:0]         tbl_rd_addr;
    logic [ENTRY_W-1:0]       tbl_rd_data;
    logic [VOLT_W-1:0]        hi_volt;
    logic [TEMP_W-1:0]        hi_temp;
    logic                     last_seg;
    logic                     seg_match;
    logic [PT_CW-1:0]         points_sat;
    logic signed [TEMP_W:0]   dy;
    logic [TEMP_W:0]          dy_mag;
    logic [SUM_W-1:0]         q_ext;
    logic [SUM_W-1:0]         interp_sum;

    t_md_req                  md_req;
    t_md_rsp                  md_rsp;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // ------------------------------------------------------------------
    // Configuration port. Only the points_in_use register exists; other
    // addresses read as zero and ignore writes.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1:2] == REG_POINTS) begin
            prdata = APB_DW'(r_points);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= POINTS_RESET;
        end else if (cfg_write && (paddr[APB_AW-1:2] == REG_POINTS)) begin
            r_points <= pwdata[CFG_W-1:0];
        end
    end

    // A register value above the table depth is treated as the full table.
    assign points_sat = (int'(r_points) > MAX_POINTS) ? PT_CW'(MAX_POINTS)
                                                      : PT_CW'(r_points);

    // ------------------------------------------------------------------
    // Breakpoint table: one word per entry holding {voltage, temperature}.
    // ------------------------------------------------------------------
    assign tbl_wr_en = accept && (i_command == CMD_LOAD)
                     && (int'(i_point_index) < MAX_POINTS);

    // The read address runs one entry ahead of the segment under test so the
    // upper breakpoint is already registered when the segment is checked.
    always_comb begin
        case (r_state)
            S_IDLE:  tbl_rd_addr = '0;
            S_FIRST: tbl_rd_addr = PT_AW'(1);
            S_SCAN:  tbl_rd_addr = r_k + PT_AW'(1) + PT_AW'(1);
            default: tbl_rd_addr = '0;
        endcase
    end

    pwl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (PT_AW'(i_point_index)),
        .i_wr_data ({i_point_volt, i_point_temp}),
        .i_rd_addr (tbl_rd_addr),
        .o_rd_data (tbl_rd_data)
    );

    assign hi_volt = tbl_rd_data[ENTRY_W-1:TEMP_W];
    assign hi_temp = tbl_rd_data[TEMP_W-1:0];

    // The last segment is closed at its upper end; all others are half open.
    assign last_seg  = ((PT_CW'(r_k) + PT_CW'(2)) == r_n);
    assign seg_match = (r_v >= r_prev_volt)
                     && (last_seg ? (r_v <= hi_volt) : (r_v < hi_volt));

    // Slope numerator works on magnitudes; the sign is reapplied at the end.
    assign dy     = $signed({hi_temp[TEMP_W-1], hi_temp})
                  - $signed({r_prev_temp[TEMP_W-1], r_prev_temp});
    assign dy_mag = dy[TEMP_W] ? (TEMP_W+1)'(-dy) : (TEMP_W+1)'(dy);

    // Since the quotient never exceeds |dy|, the signed sum fits in SUM_W bits.
    assign q_ext      = SUM_W'(md_rsp.quotient);
    assign interp_sum = {{(SUM_W-TEMP_W){r_prev_temp[TEMP_W-1]}}, r_prev_temp}
                      + (r_neg ? (SUM_W'(0) - q_ext) : q_ext);

    pwl_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_n         = r_n;
        n_k         = r_k;
        n_prev_volt = r_prev_volt;
        n_prev_temp = r_prev_temp;
        n_neg       = r_neg;
        n_res_valid = 1'b0;
        n_res_temp  = r_res_temp;
        n_res_hit   = r_res_hit;
        n_res_seg   = r_res_seg;
        n_res_zw    = r_res_zw;

        md_req.start = 1'b0;
        md_req.dv    = r_v - r_prev_volt;
        md_req.mcand = dy_mag[TEMP_W-1:0];
        md_req.dx    = hi_volt - r_prev_volt;

        case (r_state)
            S_IDLE: begin
                if (accept && (i_command == CMD_CONVERT)) begin
                    n_v = i_sample_volt;
                    n_n = points_sat;
                    if (points_sat < PT_CW'(2)) begin
                        // No segments at all: report a miss right away.
                        n_res_valid = 1'b1;
                        n_res_temp  = '0;
                        n_res_hit   = 1'b0;
                        n_res_seg   = '0;
                        n_res_zw    = 1'b0;
                    end else begin
                        n_state = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                n_prev_volt = hi_volt;
                n_prev_temp = hi_temp;
                n_k         = '0;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                if (seg_match) begin
                    n_res_seg = SEG_W'(r_k);
                    if (hi_volt == r_prev_volt) begin
                        // Zero-width segment: no division, the lower point stands.
                        n_res_valid = 1'b1;
                        n_res_temp  = r_prev_temp;
                        n_res_hit   = 1'b1;
                        n_res_zw    = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        md_req.start = 1'b1;
                        n_neg        = dy[TEMP_W];
                        n_state      = S_ARITH;
                    end
                end else if (last_seg) begin
                    n_res_valid = 1'b1;
                    n_res_temp  = '0;
                    n_res_hit   = 1'b0;
                    n_res_seg   = '0;
                    n_res_zw    = 1'b0;
                    n_state     = S_IDLE;
                end else begin
                    n_prev_volt = hi_volt;
                    n_prev_temp = hi_temp;
                    n_k         = r_k + PT_AW'(1);
                end
            end
            S_ARITH: begin
                if (md_rsp.done) begin
                    n_res_valid = 1'b1;
                    n_res_hit   = 1'b1;
                    n_res_zw    = 1'b0;
                    // Saturate when the top three bits disagree.
                    if (interp_sum[SUM_W-1:TEMP_W-1] == '0
                        || interp_sum[SUM_W-1:TEMP_W-1] == '1) begin
                        n_res_temp = interp_sum[TEMP_W-1:0];
                    end else if (interp_sum[SUM_W-1]) begin
                        n_res_temp = {1'b1, {(TEMP_W-1){1'b0}}};
                    end else begin
                        n_res_temp = {1'b0, {(TEMP_W-1){1'b1}}};
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
        r_v         <= n_v;
        r_n         <= n_n;
        r_k         <= n_k;
        r_prev_volt <= n_prev_volt;
        r_prev_temp <= n_prev_temp;
        r_neg       <= n_neg;
        r_res_temp  <= n_res_temp;
        r_res_hit   <= n_res_hit;
        r_res_seg   <= n_res_seg;
        r_res_zw    <= n_res_zw;
    end

    assign o_result_valid = r_res_valid;
    assign o_temperature  = r_res_temp;
    assign o_in_range     = r_res_hit;
    assign o_segment      = r_res_seg;
    assign o_zero_width   = r_res_zw;

endmodule

// File: test/pwl_linearizer_checker.sv
`timescale 1ns / 1ps
// Checker for the piecewise-linear sensor linearizer: mirrors the breakpoint table and
// the points-in-use register, predicts every conversion and compares each result word.
// Depends on pwl_pkg for widths, command codes and the register index.
module pwl_linearizer_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic                               i_command,
    input  logic [pwl_pkg::IDX_W-1:0]          i_point_index,
    input  logic [pwl_pkg::VOLT_W-1:0]         i_point_volt,
    input  logic signed [pwl_pkg::TEMP_W-1:0]  i_point_temp,
    input  logic [pwl_pkg::VOLT_W-1:0]         i_sample_volt,
    input  logic                               i_result_valid,
    input  logic signed [pwl_pkg::TEMP_W-1:0]  i_temperature,
    input  logic                               i_in_range,
    input  logic [pwl_pkg::SEG_W-1:0]          i_segment,
    input  logic                               i_zero_width,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [pwl_pkg::APB_AW-1:0]         i_paddr,
    input  logic [pwl_pkg::APB_DW-1:0]         i_pwdata,
    input  logic [pwl_pkg::APB_DW-1:0]         i_prdata,
    input  logic                               i_pready,
    output int                                 o_failures,
    output int                                 o_pending,
    output int                                 o_converts,
    output int                                 o_hits,
    output int                                 o_zero_widths
);
    import pwl_pkg::*;

    localparam logic [APB_AW-1:0] POINTS_ADDR = {REG_POINTS, 2'b00};
    localparam longint TEMP_HI = (longint'(1) <<< (TEMP_W - 1)) - 1;
    localparam longint TEMP_LO = -(longint'(1) <<< (TEMP_W - 1));

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     in_range;
        logic [SEG_W-1:0]         segment;
        logic                     zero_width;
    } t_reading;

    logic [VOLT_W-1:0]        bp_volts [MAX_POINTS];
    logic signed [TEMP_W-1:0] bp_temps [MAX_POINTS];
    logic [CFG_W-1:0]         points_reg = POINTS_RESET;
    t_reading                 readings_due [$];

    int fail_count   = 0;
    int convert_cnt  = 0;
    int hit_cnt      = 0;
    int zw_cnt       = 0;
    int pending_cnt  = 0;

    assign o_failures    = fail_count;
    assign o_pending     = pending_cnt;
    assign o_converts    = convert_cnt;
    assign o_hits        = hit_cnt;
    assign o_zero_widths = zw_cnt;

    // First segment that holds the sample wins; the last one is closed at its top.
    function automatic t_reading linearize(input logic [VOLT_W-1:0] volt);
        t_reading          res;
        int                span;
        logic [VOLT_W-1:0] lo;
        logic [VOLT_W-1:0] hi;
        logic              last;
        logic              found;
        longint            dv;
        longint            dx;
        longint            dy;
        longint            sum;
        res   = '0;
        found = 1'b0;
        span  = (int'(points_reg) > MAX_POINTS) ? MAX_POINTS : int'(points_reg);
        for (int k = 0; k + 1 < span; k++) begin
            lo   = bp_volts[k];
            hi   = bp_volts[k + 1];
            last = (k + 2 == span);
            if (!found && volt >= lo && (last ? volt <= hi : volt < hi)) begin
                found        = 1'b1;
                res.in_range = 1'b1;
                res.segment  = SEG_W'(k);
                if (hi == lo) begin
                    res.zero_width  = 1'b1;
                    res.temperature = bp_temps[k];
                end else begin
                    dv  = longint'(volt) - longint'(lo);
                    dx  = longint'(hi) - longint'(lo);
                    dy  = longint'(bp_temps[k + 1]) - longint'(bp_temps[k]);
                    sum = longint'(bp_temps[k]) + (dv * dy) / dx;
                    if (sum > TEMP_HI) sum = TEMP_HI;
                    if (sum < TEMP_LO) sum = TEMP_LO;
                    res.temperature = TEMP_W'(sum);
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_reading want;
        t_reading got;
        if (!i_rst_n) begin
            points_reg = POINTS_RESET;
            readings_due.delete();
        end else begin
            // Results first: a word accepted on this edge cannot have produced one yet.
            if (i_result_valid) begin
                got = {i_temperature, i_in_range, i_segment, i_zero_width};
                if (readings_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result word: temp %0d in_range %0b seg %0d zw %0b",
                             $time, got.temperature, got.in_range, got.segment, got.zero_width);
                end else begin
                    want = readings_due.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        $display("%0t: reading mismatch: expected temp %0d in_range %0b seg %0d zw %0b",
                                 $time, want.temperature, want.in_range, want.segment,
                                 want.zero_width);
                        $display("%0t:                   actual temp %0d in_range %0b seg %0d zw %0b",
                                 $time, got.temperature, got.in_range, got.segment,
                                 got.zero_width);
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_command == CMD_LOAD) begin
                    bp_volts[i_point_index] = i_point_volt;
                    bp_temps[i_point_index] = i_point_temp;
                end else begin
                    want = linearize(i_sample_volt);
                    readings_due.push_back(want);
                    convert_cnt++;
                    if (want.in_range) hit_cnt++;
                    if (want.zero_width) zw_cnt++;
                end
            end
            if (i_psel && i_penable && i_pready && i_paddr == POINTS_ADDR) begin
                if (i_pwrite) begin
                    points_reg = i_pwdata[CFG_W-1:0];
                end else if (i_prdata !== APB_DW'(points_reg)) begin
                    fail_count++;
                    $display("%0t: points_in_use read back: expected %0d, actual %0d",
                             $time, points_reg, i_prdata);
                end
            end
        end
        pending_cnt = readings_due.size();
    end

endmodule

// File: test/tb_piecewise_linear_sensor_linearizer_unit.sv
`timescale 1ns / 1ps
// Testbench top for the piecewise-linear sensor linearizer: clock, reset, stimulus, verdict.
// Depends on pwl_pkg, piecewise_linear_sensor_linearizer_unit and pwl_linearizer_checker.
module tb_piecewise_linear_sensor_linearizer_unit;
    import pwl_pkg::*;

    localparam int ITEM_TARGET   = 1600;
    // In the last stretch of words pick_gap adds no idle cycles after a word.
    localparam int TAIL_ITEMS    = 200;
    // Settle time after a drain; it covers a full-table interpolation with margin.
    localparam int SETTLE_CYCLES = 64;
    // Watchdog bound, well above the slowest legal run of ITEM_TARGET words.
    localparam int CYCLE_LIMIT   = 600000;
    localparam logic [APB_AW-1:0] POINTS_ADDR = {REG_POINTS, 2'b00};

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic                       i_command;
    logic [IDX_W-1:0]           i_point_index;
    logic [VOLT_W-1:0]          i_point_volt;
    logic signed [TEMP_W-1:0]   i_point_temp;
    logic [VOLT_W-1:0]          i_sample_volt;
    logic                       o_result_valid;
    logic signed [TEMP_W-1:0]   o_temperature;
    logic                       o_in_range;
    logic [SEG_W-1:0]           o_segment;
    logic                       o_zero_width;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_AW-1:0]          paddr;
    logic [APB_DW-1:0]          pwdata;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    int failures;
    int pending;
    int converts;
    int hits;
    int zero_widths;
    int cycle_count   = 0;
    int words_sent    = 0;
    int loads_sent    = 0;
    int settings_used = 1;

    // The stimulus keeps its own view of the breakpoint voltages so that it can aim
    // samples at segments, breakpoints and the space outside the table.
    logic [VOLT_W-1:0] plan_volts [MAX_POINTS];

    piecewise_linear_sensor_linearizer_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_point_index  (i_point_index),
        .i_point_volt   (i_point_volt),
        .i_point_temp   (i_point_temp),
        .i_sample_volt  (i_sample_volt),
        .o_result_valid (o_result_valid),
        .o_temperature  (o_temperature),
        .o_in_range     (o_in_range),
        .o_segment      (o_segment),
        .o_zero_width   (o_zero_width),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    pwl_linearizer_checker i_reading_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_command      (i_command),
        .i_point_index  (i_point_index),
        .i_point_volt   (i_point_volt),
        .i_point_temp   (i_point_temp),
        .i_sample_volt  (i_sample_volt),
        .i_result_valid (o_result_valid),
        .i_temperature  (o_temperature),
        .i_in_range     (o_in_range),
        .i_segment      (o_segment),
        .i_zero_width   (o_zero_width),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_failures     (failures),
        .o_pending      (pending),
        .o_converts     (converts),
        .o_hits         (hits),
        .o_zero_widths  (zero_widths)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Idle cycles after a word: none in quiet phases or in the tail, otherwise a
    // burst of random length about a third of the time.
    function automatic int pick_gap(input logic idles);
        if (!idles || words_sent >= ITEM_TARGET - TAIL_ITEMS || $urandom_range(0, 2) != 0) begin
            return 0;
        end
        return $urandom_range(1, 11);
    endfunction

    // Presents one word and holds it until the block takes it. busy is sampled on
    // the falling edge, where it is settled for the rising edge that follows. start
    // stays high when no gap follows, so words can go back to back.
    task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [VOLT_W-1:0] volt, input logic [TEMP_W-1:0] temp,
                             input logic [VOLT_W-1:0] sample, input int gap);
        logic taken;
        start         <= 1'b1;
        i_command     <= cmd;
        i_point_index <= idx;
        i_point_volt  <= volt;
        i_point_temp  <= temp;
        i_sample_volt <= sample;
        do begin
            @(negedge i_clk);
            taken = (busy === 1'b0);
            @(posedge i_clk);
        end while (!taken);
        words_sent++;
        if (cmd == CMD_LOAD) loads_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // One register access: setup phase, then access phase until pready, then psel
    // low again so that a following access never lands in the same time step.
    task automatic apb_access(input logic write, input logic [APB_DW-1:0] data);
        logic ready;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= POINTS_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            ready = (pready === 1'b1);
            @(posedge i_clk);
        end while (!ready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stops sending and waits until every predicted reading has come back, which
    // leaves the block idle, then waits out the optional settle time.
    task automatic drain_results(input int settle);
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    initial begin
        int                n_set;
        int                span;
        int                lo_v;
        int                hi_v;
        int                pick;
        int                off;
        int                table_kind;
        logic              phase_idles;
        logic [VOLT_W-1:0] sample;
        logic [VOLT_W-1:0] swap_v;
        logic [TEMP_W-1:0] temp_v;

        // Every input is known from time zero; reset is held low before release.
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_command     <= CMD_LOAD;
        i_point_index <= '0;
        i_point_volt  <= '0;
        i_point_temp  <= '0;
        i_sample_volt <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset setting of eleven points. The table holds
        // the temperature extremes side by side, one out-of-order voltage and a
        // zero-width last segment.
        apb_access(1'b0, '0);
        send_word(CMD_LOAD, 4'd0, 16'h0100, 20'h80000, 16'hFFFF, pick_gap(1'b1));
        send_word(CMD_LOAD, 4'd1, 16'h1000, 20'h7FFFF, 16'h0000, pick_gap(1'b1));
        send_word(CMD_LOAD, 4'd2, 16'h2000, 20'd0, 16'hAAAA, pick_gap(1'b1));
        send_word(CMD_LOAD, 4'd3, 16'h3000, 20'hFFFFF, 16'h5555, pick_gap(1'b1));
        send_word(CMD_LOAD, 4'd4, 16'h5000, 20'd1000, 16'h0F0F, pick_gap(1'b1));
        send_word(CMD_LOAD, 4'd5, 16'h4000, 20'(-2000), 16'hF0F0, pick_gap(1'b1));
        send_word(CMD_LOAD, 4'd6, 16'h6000, 20'd300000, 16'h1234, pick_gap(1'b1));
        send_word(CMD_LOAD, 4'd7, 16'h8000, 20'(-300000), 16'h4321, pick_gap(1'b1));
        send_word(CMD_LOAD, 4'd8, 16'hA000, 20'd12345, 16'h0000, pick_gap(1'b1));
        send_word(CMD_LOAD, 4'd9, 16'hF000, 20'h7FFFF, 16'hFFFF, pick_gap(1'b1));
        send_word(CMD_LOAD, 4'd10, 16'hF000, 20'h80000, 16'h0001, pick_gap(1'b1));
        // Below the table, on its first point, then a full-scale swing inside one segment.
        send_word(CMD_CONVERT, 4'd15, 16'hFFFF, 20'hFFFFF, 16'h0000, pick_gap(1'b1));
        send_word(CMD_CONVERT, 4'd0, 16'h0000, 20'h00000, 16'h0100, pick_gap(1'b1));
        send_word(CMD_CONVERT, 4'd5, 16'h5A5A, 20'h5A5A5, 16'h0800, pick_gap(1'b1));
        // Around the out-of-order entry the first matching segment has to win.
        send_word(CMD_CONVERT, 4'd10, 16'hA5A5, 20'hA5A5A, 16'h4800, pick_gap(1'b1));
        send_word(CMD_CONVERT, 4'd3, 16'h3C3C, 20'h3C3C3, 16'h4000, pick_gap(1'b1));
        send_word(CMD_CONVERT, 4'd12, 16'hC3C3, 20'hC3C3C, 16'h5800, pick_gap(1'b1));
        // An inner breakpoint, the zero-width top segment, an ordinary segment, above.
        send_word(CMD_CONVERT, 4'd7, 16'h7777, 20'h77777, 16'h8000, pick_gap(1'b1));
        send_word(CMD_CONVERT, 4'd9, 16'h9999, 20'h99999, 16'hF000, pick_gap(1'b1));
        send_word(CMD_CONVERT, 4'd6, 16'h6666, 20'h66666, 16'hE000, pick_gap(1'b1));
        send_word(CMD_CONVERT, 4'd1, 16'h1111, 20'h11111, 16'hFFFF, pick_gap(1'b1));

        // Random phases: each one sets points_in_use while the block is idle, loads a
        // fresh sixteen-entry table and then converts samples aimed at that table.
        // The first phases walk the register extremes, including values below two
        // and above the table size.
        for (int phase = 0; words_sent < ITEM_TARGET; phase++) begin
            case (phase)
                0: n_set = 2;
                1: n_set = 16;
                2: n_set = 0;
                3: n_set = 1;
                4: n_set = 31;
                5: n_set = 17;
                default: n_set = ($urandom_range(0, 3) != 0) ? $urandom_range(2, 16)
                                                             : $urandom_range(0, 31);
            endcase
            drain_results(SETTLE_CYCLES);
            apb_access(1'b1, {27'($urandom), 5'(n_set)});
            apb_access(1'b0, '0);
            settings_used++;
            span        = (n_set > MAX_POINTS) ? MAX_POINTS : n_set;
            phase_idles = ($urandom_range(0, 3) != 0);

            // Most tables are ascending in the part that is searched. Some span the
            // whole voltage range, some end in a zero-width segment, some carry an
            // inner duplicate or unit-wide steps, and one in eight stays unsorted.
            table_kind = $urandom_range(0, 7);
            for (int k = 0; k < MAX_POINTS; k++) plan_volts[k] = 16'($urandom);
            if (table_kind != 0) begin
                for (int k = 1; k < span; k++) begin
                    for (int j = k; j > 0 && plan_volts[j-1] > plan_volts[j]; j--) begin
                        swap_v          = plan_volts[j];
                        plan_volts[j]   = plan_volts[j-1];
                        plan_volts[j-1] = swap_v;
                    end
                end
            end
            if (table_kind == 1 && span >= 2) begin
                plan_volts[0]      = '0;
                plan_volts[span-1] = '1;
            end
            if (table_kind == 2 && span >= 2) plan_volts[span-1] = plan_volts[span-2];
            if (table_kind == 3 && span >= 3) begin
                off                = $urandom_range(0, span - 3);
                plan_volts[off+1]  = plan_volts[off];
            end
            if (table_kind == 4) begin
                for (int k = 1; k < span; k++) plan_volts[k] = 16'(plan_volts[0] + k);
            end

            off = $urandom_range(0, MAX_POINTS - 1);
            for (int k = 0; k < MAX_POINTS; k++) begin
                temp_v = 20'($urandom);
                if ($urandom_range(0, 5) == 0) temp_v = $urandom_range(0, 1) ? 20'h80000 : 20'h7FFFF;
                send_word(CMD_LOAD, IDX_W'((k + off) % MAX_POINTS),
                          plan_volts[(k + off) % MAX_POINTS], temp_v, 16'($urandom),
                          pick_gap(phase_idles));
            end

            lo_v = 0;
            hi_v = 16'hFFFF;
            if (span >= 1) begin
                lo_v = plan_volts[0];
                hi_v = plan_volts[0];
                for (int k = 1; k < span; k++) begin
                    if (plan_volts[k] < lo_v) lo_v = plan_volts[k];
                    if (plan_volts[k] > hi_v) hi_v = plan_volts[k];
                end
            end

            for (int c = $urandom_range(40, 70); c > 0; c--) begin
                // Now and then a stray load overwrites one breakpoint mid-phase.
                if ($urandom_range(0, 19) == 0) begin
                    off             = $urandom_range(0, MAX_POINTS - 1);
                    plan_volts[off] = 16'($urandom);
                    send_word(CMD_LOAD, IDX_W'(off), plan_volts[off], 20'($urandom),
                              16'($urandom), pick_gap(phase_idles));
                end
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    sample = 16'($urandom_range(lo_v, hi_v));
                end else if (pick < 65) begin
                    sample = plan_volts[$urandom_range(0, (span > 0) ? span - 1 : MAX_POINTS - 1)];
                end else if (pick < 72) begin
                    sample = '0;
                end else if (pick < 79) begin
                    sample = '1;
                end else if (pick < 87) begin
                    if (lo_v > 0 && (hi_v == 16'hFFFF || $urandom_range(0, 1) == 0)) begin
                        sample = 16'($urandom_range(0, lo_v - 1));
                    end else if (hi_v < 16'hFFFF) begin
                        sample = 16'($urandom_range(hi_v + 1, 16'hFFFF));
                    end else begin
                        sample = 16'($urandom);
                    end
                end else begin
                    sample = 16'($urandom);
                end
                // Occasionally hold off until every outstanding reading is back.
                if ($urandom_range(0, 99) == 0) drain_results(0);
                send_word(CMD_CONVERT, IDX_W'($urandom), 16'($urandom), 20'($urandom),
                          sample, pick_gap(phase_idles));
            end
        end

        drain_results(SETTLE_CYCLES);
        @(negedge i_clk);
        $display("Sent %0d words (%0d breakpoint loads, %0d conversions) over %0d table settings.",
                 words_sent, loads_sent, converts, settings_used);
        $display("Conversions: %0d inside a segment, %0d of them zero-width, %0d outside the table.",
                 hits, zero_widths, converts - hits);
        if (failures == 0 && pending == 0) begin
            $display("** piecewise_linear_sensor_linearizer_unit: PASSED **");
        end else begin
            $display("** piecewise_linear_sensor_linearizer_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial begin
        do @(negedge i_clk); while (cycle_count < CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d readings still due.", CYCLE_LIMIT, pending);
        $display("** piecewise_linear_sensor_linearizer_unit: FAILED **");
        $finish;
    end

endmodule
